/* hdl/pts_pkg.sv */
// Package of the priority task scheduler: operation, mode, status and sequencer
// state codes, default sizes and the item and result structures. No dependencies.
package pts_pkg;

  localparam int unsigned TasksDef       = 16;
  localparam int unsigned FlagBitsDef    = 32;
  localparam int unsigned TimeoutBitsDef = 32;
  localparam int unsigned PromiseBitsDef = 32;

  typedef enum logic [3:0] {
    OP_TICK    = 4'd0,
    OP_ADD     = 4'd1,
    OP_SLEEP   = 4'd2,
    OP_WFLAGS  = 4'd3,
    OP_TAKE    = 4'd4,
    OP_SET     = 4'd5,
    OP_AWAIT   = 4'd6,
    OP_RESOLVE = 4'd7,
    OP_IDLE    = 4'd8,
    OP_PUSHED  = 4'd9,
    OP_JOIN    = 4'd10
  } op_e;

  typedef enum logic [2:0] {
    MODE_READY = 3'd0,
    MODE_WTIME = 3'd1,
    MODE_WFLAG = 3'd2,
    MODE_WPROM = 3'd3,
    MODE_WLOOP = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_ID    = 2'd1,
    ST_NO_WORKER = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_OP,
    SQ_TICK,
    SQ_WAKE,
    SQ_RESOLVE,
    SQ_PICK,
    SQ_KEEP,
    SQ_DONE
  } seq_e;

  typedef struct packed {
    logic [3:0]  op;
    logic [4:0]  task_id;
    logic [7:0]  task_group;
    logic        event_worker;
    logic [31:0] amount;
    logic [31:0] flag_mask;
    logic [31:0] promise_tag;
  } item_t;

  typedef struct packed {
    logic [3:0]  running_task;
    logic        running_valid;
    logic        switch_request;
    logic [31:0] flags_read;
    logic [1:0]  status;
  } res_t;

endpackage

/* hdl/pts_if.sv */
// Handshake channels of the priority task scheduler: the operation channel
// and the result channel. Depends on nothing.
interface pts_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  op;
  logic [4:0]  task_id;
  logic [7:0]  task_group;
  logic        event_worker;
  logic [31:0] amount;
  logic [31:0] flag_mask;
  logic [31:0] promise_tag;

  modport source(output valid, op, task_id, task_group, event_worker, amount, flag_mask,
                 promise_tag, input ready);
  modport sink(input valid, op, task_id, task_group, event_worker, amount, flag_mask,
               promise_tag, output ready);
endinterface

interface pts_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  running_task;
  logic        running_valid;
  logic        switch_request;
  logic [31:0] flags_read;
  logic [1:0]  status;

  modport source(output valid, running_task, running_valid, switch_request, flags_read,
                 status, input ready);
  modport sink(input valid, running_task, running_valid, switch_request, flags_read,
               status, output ready);
endinterface

/* hdl/pts_table.sv */
// Task table of the priority task scheduler: one entry per task, one
// address per cycle for a read and a read-modify-write. Uses pts_pkg.
module pts_table
  import pts_pkg::*;
#(
  parameter int unsigned TASKS        = TasksDef,
  parameter int unsigned FLAG_BITS    = FlagBitsDef,
  parameter int unsigned TIMEOUT_BITS = TimeoutBitsDef,
  parameter int unsigned PROMISE_BITS = PromiseBitsDef,
  localparam int unsigned IdW         = $clog2(TASKS)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [IdW-1:0]          addr_i,
  input  logic                    wr_en_i,
  input  mode_e                   wr_mode_i,
  input  logic [TIMEOUT_BITS-1:0] wr_ticks_i,
  input  logic [FLAG_BITS-1:0]    wr_flags_i,
  input  logic [FLAG_BITS-1:0]    wr_mask_i,
  input  logic [PROMISE_BITS-1:0] wr_prom_i,
  input  logic [7:0]              wr_grp_i,
  input  logic                    wr_worker_i,
  output mode_e                   rd_mode_o,
  output logic [TIMEOUT_BITS-1:0] rd_ticks_o,
  output logic [FLAG_BITS-1:0]    rd_flags_o,
  output logic [FLAG_BITS-1:0]    rd_mask_o,
  output logic [PROMISE_BITS-1:0] rd_prom_o,
  output logic [7:0]              rd_grp_o,
  output logic                    rd_worker_o
);

  mode_e                   mode_q   [TASKS];
  logic [TIMEOUT_BITS-1:0] ticks_q  [TASKS];
  logic [FLAG_BITS-1:0]    flags_q  [TASKS];
  logic [FLAG_BITS-1:0]    mask_q   [TASKS];
  logic [PROMISE_BITS-1:0] prom_q   [TASKS];
  logic [7:0]              grp_q    [TASKS];
  logic                    worker_q [TASKS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TASKS; i++) begin
        mode_q[i]   <= MODE_READY;
        ticks_q[i]  <= '0;
        flags_q[i]  <= '0;
        mask_q[i]   <= '0;
        prom_q[i]   <= '0;
        grp_q[i]    <= '0;
        worker_q[i] <= 1'b0;
      end
    end else if (wr_en_i) begin
      mode_q[addr_i]   <= wr_mode_i;
      ticks_q[addr_i]  <= wr_ticks_i;
      flags_q[addr_i]  <= wr_flags_i;
      mask_q[addr_i]   <= wr_mask_i;
      prom_q[addr_i]   <= wr_prom_i;
      grp_q[addr_i]    <= wr_grp_i;
      worker_q[addr_i] <= wr_worker_i;
    end
  end

  assign rd_mode_o   = mode_q[addr_i];
  assign rd_ticks_o  = ticks_q[addr_i];
  assign rd_flags_o  = flags_q[addr_i];
  assign rd_mask_o   = mask_q[addr_i];
  assign rd_prom_o   = prom_q[addr_i];
  assign rd_grp_o    = grp_q[addr_i];
  assign rd_worker_o = worker_q[addr_i];

endmodule

/* hdl/pts_seq.sv */
// Sequencer of the priority task scheduler: walks the task table one entry
// a cycle for each operation and the pick that follows. Uses pts_pkg.
module pts_seq
  import pts_pkg::*;
#(
  parameter int unsigned TASKS        = TasksDef,
  parameter int unsigned FLAG_BITS    = FlagBitsDef,
  parameter int unsigned TIMEOUT_BITS = TimeoutBitsDef,
  parameter int unsigned PROMISE_BITS = PromiseBitsDef,
  localparam int unsigned IdW         = $clog2(TASKS)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    item_valid_i,
  output logic                    item_ready_o,
  input  item_t                   item_i,
  output logic                    res_valid_o,
  input  logic                    res_ready_i,
  output res_t                    res_o,
  output logic                    halted_o,
  output logic [IdW-1:0]          addr_o,
  output logic                    wr_en_o,
  output mode_e                   wr_mode_o,
  output logic [TIMEOUT_BITS-1:0] wr_ticks_o,
  output logic [FLAG_BITS-1:0]    wr_flags_o,
  output logic [FLAG_BITS-1:0]    wr_mask_o,
  output logic [PROMISE_BITS-1:0] wr_prom_o,
  output logic [7:0]              wr_grp_o,
  output logic                    wr_worker_o,
  input  mode_e                   rd_mode_i,
  input  logic [TIMEOUT_BITS-1:0] rd_ticks_i,
  input  logic [FLAG_BITS-1:0]    rd_flags_i,
  input  logic [FLAG_BITS-1:0]    rd_mask_i,
  input  logic [PROMISE_BITS-1:0] rd_prom_i,
  input  logic [7:0]              rd_grp_i,
  input  logic                    rd_worker_i
);

  seq_e                    st_q, st_d;
  logic [IdW-1:0]          idx_q, idx_d;
  op_e                     op_q, op_d;
  logic [4:0]              id_q, id_d;
  logic [7:0]              grp_q, grp_d;
  logic                    wk_q, wk_d;
  logic [TIMEOUT_BITS-1:0] amt_q, amt_d;
  logic [FLAG_BITS-1:0]    msk_q, msk_d;
  logic [PROMISE_BITS-1:0] prm_q, prm_d;
  status_e                 status_q, status_d;
  logic [31:0]             fread_q, fread_d;
  logic                    sw_q, sw_d;
  logic [IdW-1:0]          next_q, next_d;
  logic [7:0]              ngrp_q, ngrp_d;
  logic [IdW-1:0]          top_q, top_d;
  logic [IdW-1:0]          topw_q, topw_d;
  logic [IdW-1:0]          cur_q, cur_d;
  logic                    cur_set_q, cur_set_d;
  logic                    wfree_q, wfree_d;
  logic                    halt_q, halt_d;
  logic                    id_ok;
  logic [IdW-1:0]          id_idx;
  logic [IdW-1:0]          nxt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= SQ_IDLE;
      top_q     <= '0;
      topw_q    <= '0;
      cur_q     <= '0;
      cur_set_q <= 1'b0;
      wfree_q   <= 1'b1;
      halt_q    <= 1'b0;
    end else begin
      st_q      <= st_d;
      top_q     <= top_d;
      topw_q    <= topw_d;
      cur_q     <= cur_d;
      cur_set_q <= cur_set_d;
      wfree_q   <= wfree_d;
      halt_q    <= halt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    op_q     <= op_d;
    id_q     <= id_d;
    grp_q    <= grp_d;
    wk_q     <= wk_d;
    amt_q    <= amt_d;
    msk_q    <= msk_d;
    prm_q    <= prm_d;
    status_q <= status_d;
    fread_q  <= fread_d;
    sw_q     <= sw_d;
    next_q   <= next_d;
    ngrp_q   <= ngrp_d;
  end

  assign id_ok  = ({27'd0, id_q} < 32'(TASKS));
  assign id_idx = IdW'(id_q);

  always_comb begin
    st_d      = st_q;
    idx_d     = idx_q;
    op_d      = op_q;
    id_d      = id_q;
    grp_d     = grp_q;
    wk_d      = wk_q;
    amt_d     = amt_q;
    msk_d     = msk_q;
    prm_d     = prm_q;
    status_d  = status_q;
    fread_d   = fread_q;
    sw_d      = sw_q;
    next_d    = next_q;
    ngrp_d    = ngrp_q;
    top_d     = top_q;
    topw_d    = topw_q;
    cur_d     = cur_q;
    cur_set_d = cur_set_q;
    wfree_d   = wfree_q;
    halt_d    = halt_q;
    nxt       = next_q;

    item_ready_o = 1'b0;
    res_valid_o  = 1'b0;
    addr_o       = cur_q;
    wr_en_o      = 1'b0;
    wr_mode_o    = rd_mode_i;
    wr_ticks_o   = rd_ticks_i;
    wr_flags_o   = rd_flags_i;
    wr_mask_o    = rd_mask_i;
    wr_prom_o    = rd_prom_i;
    wr_grp_o     = rd_grp_i;
    wr_worker_o  = rd_worker_i;

    case (st_q)
      SQ_IDLE: begin
        item_ready_o = 1'b1;
        if (item_valid_i) begin
          op_d     = op_e'(item_i.op);
          id_d     = item_i.task_id;
          grp_d    = item_i.task_group;
          wk_d     = item_i.event_worker;
          amt_d    = TIMEOUT_BITS'(item_i.amount);
          msk_d    = FLAG_BITS'(item_i.flag_mask);
          prm_d    = PROMISE_BITS'(item_i.promise_tag);
          status_d = ST_OK;
          fread_d  = '0;
          sw_d     = 1'b0;
          st_d     = halt_q ? SQ_DONE : SQ_OP;
        end
      end
      SQ_OP: begin
        st_d  = SQ_PICK;
        idx_d = top_q;
        case (op_q)
          OP_TICK: begin
            if (top_q != '0) st_d = SQ_TICK;
          end
          OP_ADD: begin
            addr_o = id_idx;
            if (!id_ok) begin
              status_d = ST_BAD_ID;
              halt_d   = 1'b1;
              st_d     = SQ_DONE;
            end else begin
              wr_en_o     = 1'b1;
              wr_mode_o   = wk_q ? MODE_WLOOP : MODE_READY;
              wr_ticks_o  = '0;
              wr_flags_o  = '0;
              wr_mask_o   = '0;
              wr_prom_o   = '0;
              wr_grp_o    = grp_q;
              wr_worker_o = wk_q;
              if (id_idx > top_q) begin
                top_d = id_idx;
                idx_d = id_idx;
              end
              if (wk_q && id_idx > topw_q) topw_d = id_idx;
            end
          end
          OP_SLEEP: begin
            if (cur_set_q) begin
              wr_en_o    = 1'b1;
              wr_ticks_o = amt_q;
              wr_mode_o  = MODE_WTIME;
            end
          end
          OP_WFLAGS: begin
            if (cur_set_q) begin
              wr_en_o    = 1'b1;
              wr_mask_o  = msk_q;
              wr_ticks_o = amt_q;
              wr_mode_o  = MODE_WFLAG;
            end
          end
          OP_TAKE: begin
            if (cur_set_q) begin
              fread_d    = 32'(rd_flags_i);
              wr_en_o    = 1'b1;
              wr_flags_o = rd_flags_i & ~msk_q;
            end
          end
          OP_SET: begin
            addr_o = id_idx;
            if (id_ok) begin
              wr_en_o    = 1'b1;
              wr_flags_o = rd_flags_i | msk_q;
            end else begin
              status_d = ST_BAD_ID;
            end
          end
          OP_AWAIT: begin
            if (cur_set_q) begin
              wr_en_o   = 1'b1;
              wr_prom_o = prm_q;
              wr_mode_o = MODE_WPROM;
              st_d      = SQ_WAKE;
              idx_d     = topw_q;
            end
          end
          OP_RESOLVE: begin
            st_d  = SQ_RESOLVE;
            idx_d = topw_q;
          end
          OP_IDLE: begin
            if (cur_set_q) begin
              wr_en_o   = 1'b1;
              wr_mode_o = MODE_WLOOP;
              wfree_d   = 1'b0;
            end
          end
          OP_PUSHED: begin
            if (!wfree_q) begin
              st_d  = SQ_WAKE;
              idx_d = topw_q;
            end
          end
          OP_JOIN: begin
            st_d  = SQ_WAKE;
            idx_d = topw_q;
          end
          default: begin
            st_d = SQ_PICK;
          end
        endcase
      end
      SQ_TICK: begin
        addr_o = idx_q;
        if (rd_ticks_i != '0) begin
          wr_en_o = 1'b1;
          if (rd_ticks_i == TIMEOUT_BITS'(1)) begin
            wr_ticks_o = '0;
            wr_mode_o  = MODE_READY;
          end else begin
            wr_ticks_o = rd_ticks_i - TIMEOUT_BITS'(1);
          end
        end
        if (idx_q == IdW'(1)) begin
          st_d  = SQ_PICK;
          idx_d = top_q;
        end else begin
          idx_d = idx_q - IdW'(1);
        end
      end
      SQ_WAKE: begin
        addr_o = idx_q;
        if (idx_q == '0) begin
          status_d = ST_NO_WORKER;
          halt_d   = 1'b1;
          st_d     = SQ_DONE;
        end else if (rd_worker_i &&
                     (rd_mode_i == MODE_WLOOP || rd_mode_i == MODE_READY)) begin
          wr_en_o   = 1'b1;
          wr_mode_o = MODE_READY;
          wfree_d   = 1'b1;
          st_d      = SQ_PICK;
          idx_d     = top_q;
        end else begin
          idx_d = idx_q - IdW'(1);
        end
      end
      SQ_RESOLVE: begin
        addr_o = idx_q;
        if (idx_q == '0) begin
          st_d  = SQ_PICK;
          idx_d = top_q;
        end else if (rd_mode_i == MODE_WPROM && rd_prom_i == prm_q) begin
          wr_en_o   = 1'b1;
          wr_prom_o = '0;
          wr_mode_o = MODE_READY;
          st_d      = SQ_PICK;
          idx_d     = top_q;
        end else begin
          idx_d = idx_q - IdW'(1);
        end
      end
      SQ_PICK: begin
        // Index zero is only read for the idle task's group.
        addr_o = idx_q;
        if (idx_q == '0) begin
          next_d = '0;
          ngrp_d = rd_grp_i;
          st_d   = SQ_KEEP;
        end else if (rd_mode_i == MODE_WFLAG && (rd_flags_i & rd_mask_i) != '0) begin
          wr_en_o   = 1'b1;
          wr_mode_o = MODE_READY;
          next_d    = idx_q;
          ngrp_d    = rd_grp_i;
          st_d      = SQ_KEEP;
        end else if (rd_mode_i == MODE_READY) begin
          next_d = idx_q;
          ngrp_d = rd_grp_i;
          st_d   = SQ_KEEP;
        end else begin
          idx_d = idx_q - IdW'(1);
        end
      end
      SQ_KEEP: begin
        addr_o = cur_q;
        if (cur_set_q && ngrp_q == rd_grp_i && rd_mode_i == MODE_READY) nxt = cur_q;
        sw_d      = !cur_set_q || nxt != cur_q;
        cur_d     = nxt;
        cur_set_d = 1'b1;
        st_d      = SQ_DONE;
      end
      SQ_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) st_d = SQ_IDLE;
      end
      default: begin
        st_d = SQ_IDLE;
      end
    endcase
  end

  assign res_o.running_task   = 4'(cur_q);
  assign res_o.running_valid  = cur_set_q;
  assign res_o.switch_request = sw_q;
  assign res_o.flags_read     = fread_q;
  assign res_o.status         = status_q;
  assign halted_o             = halt_q;

endmodule

/* hdl/priority_task_scheduler.sv */
// Top level of the priority task scheduler: task table, sequencer and the
// result register. Uses pts_pkg, pts_if, pts_table and pts_seq.
//
// One operation transaction is taken at a time; the block stays not ready
// until its work is done. Every operation that neither halts the block nor
// meets a halted block then ends with a pick that walks the task table from
// the highest added task down, one entry per cycle, and a last step compares
// with the current task. A tick first walks the table once more, from the
// highest added task down to task one, and wake, resolve and await first
// search the table from the highest worker task down. The task table has a
// single port, which is read and rewritten at one entry per cycle. Results go
// into an output register, so the next operation is taken while a result
// still waits to be drained; a full register holds the sequencer in its last
// state. After a failed add or a failed worker wake the block halts: every
// later transaction answers with the current task, switch_request low and
// status ok, and only reset clears the halt. Tasks at or above TASKS are
// refused with status one.
module priority_task_scheduler
  import pts_pkg::*;
#(
  parameter int unsigned TASKS        = TasksDef,
  parameter int unsigned FLAG_BITS    = FlagBitsDef,
  parameter int unsigned TIMEOUT_BITS = TimeoutBitsDef,
  parameter int unsigned PROMISE_BITS = PromiseBitsDef,
  localparam int unsigned IdW         = $clog2(TASKS)
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pts_in_if.sink    in_i,
  pts_out_if.source out_o
);

  item_t                   item;
  res_t                    res, res_q;
  logic                    res_valid, res_ready, halted;
  logic                    out_valid_q;
  logic [IdW-1:0]          addr;
  logic                    wr_en;
  mode_e                   wr_mode, rd_mode;
  logic [TIMEOUT_BITS-1:0] wr_ticks, rd_ticks;
  logic [FLAG_BITS-1:0]    wr_flags, rd_flags, wr_mask, rd_mask;
  logic [PROMISE_BITS-1:0] wr_prom, rd_prom;
  logic [7:0]              wr_grp, rd_grp;
  logic                    wr_worker, rd_worker;

  assign item.op           = in_i.op;
  assign item.task_id      = in_i.task_id;
  assign item.task_group   = in_i.task_group;
  assign item.event_worker = in_i.event_worker;
  assign item.amount       = in_i.amount;
  assign item.flag_mask    = in_i.flag_mask;
  assign item.promise_tag  = in_i.promise_tag;

  pts_table #(
    .TASKS(TASKS), .FLAG_BITS(FLAG_BITS),
    .TIMEOUT_BITS(TIMEOUT_BITS), .PROMISE_BITS(PROMISE_BITS)
  ) u_table (
    .clk_i, .rst_ni,
    .addr_i(addr), .wr_en_i(wr_en),
    .wr_mode_i(wr_mode), .wr_ticks_i(wr_ticks), .wr_flags_i(wr_flags),
    .wr_mask_i(wr_mask), .wr_prom_i(wr_prom), .wr_grp_i(wr_grp),
    .wr_worker_i(wr_worker),
    .rd_mode_o(rd_mode), .rd_ticks_o(rd_ticks), .rd_flags_o(rd_flags),
    .rd_mask_o(rd_mask), .rd_prom_o(rd_prom), .rd_grp_o(rd_grp),
    .rd_worker_o(rd_worker)
  );

  pts_seq #(
    .TASKS(TASKS), .FLAG_BITS(FLAG_BITS),
    .TIMEOUT_BITS(TIMEOUT_BITS), .PROMISE_BITS(PROMISE_BITS)
  ) u_seq (
    .clk_i, .rst_ni,
    .item_valid_i(in_i.valid), .item_ready_o(in_i.ready), .item_i(item),
    .res_valid_o(res_valid), .res_ready_i(res_ready), .res_o(res),
    .halted_o(halted),
    .addr_o(addr), .wr_en_o(wr_en),
    .wr_mode_o(wr_mode), .wr_ticks_o(wr_ticks), .wr_flags_o(wr_flags),
    .wr_mask_o(wr_mask), .wr_prom_o(wr_prom), .wr_grp_o(wr_grp),
    .wr_worker_o(wr_worker),
    .rd_mode_i(rd_mode), .rd_ticks_i(rd_ticks), .rd_flags_i(rd_flags),
    .rd_mask_i(rd_mask), .rd_prom_i(rd_prom), .rd_grp_i(rd_grp),
    .rd_worker_i(rd_worker)
  );

  // The result register is free when empty or when it drains this cycle.
  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      res_q <= res;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.running_task   = res_q.running_task;
  assign out_o.running_valid  = res_q.running_valid;
  assign out_o.switch_request = res_q.switch_request;
  assign out_o.flags_read     = res_q.flags_read;
  assign out_o.status         = res_q.status;

  // A switch can only be reported once some task has been scheduled.
  a_switch_needs_running : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.switch_request |-> res_q.running_valid)
    else $error("switch reported without a running task");

  // Only one transaction is in work at a time.
  a_one_at_a_time : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("second transaction taken while one is in work");

  // Once halted, the block never reports a switch again. The failing
  // transaction itself still carries its error status.
  a_halt_no_switch : assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted && res_valid |-> !res.switch_request)
    else $error("halted block changed its schedule");

  // Status codes stay within the defined set.
  a_status_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.status == ST_OK || res_q.status == ST_BAD_ID ||
                     res_q.status == ST_NO_WORKER))
    else $error("undefined status code");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the priority task scheduler: directed and random
// operations against a task table model kept in the bench. Needs all hdl files.
module tb_top;
  import pts_pkg::*;

  localparam int unsigned NumTasks   = TasksDef;
  localparam int unsigned CycleLimit = 900000;
  localparam int unsigned RandItems  = 1000;

  // Copy of the scheduler state that the bench keeps in step with the block.
  typedef struct {
    mode_e       mode      [NumTasks];
    logic [31:0] ticks     [NumTasks];
    logic [31:0] flags     [NumTasks];
    logic [31:0] wait_mask [NumTasks];
    logic [31:0] promise   [NumTasks];
    logic [7:0]  grp       [NumTasks];
    logic        is_worker [NumTasks];
    int unsigned top_id;
    int unsigned top_worker;
    logic [3:0]  cur_id;
    logic        cur_set;
    logic        workers_free;
    logic        halted;
  } sched_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  pts_in_if  in_if ();
  pts_out_if out_if ();

  priority_task_scheduler u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  sched_t      sched;
  res_t        expected_q[$];
  int unsigned errors      = 0;
  int unsigned cycles      = 0;
  int unsigned burst_left  = 0;
  int unsigned hold_cycles = 0;

  // ---------------------------------------------------------------------------
  // Scheduler model: each function mirrors one part of an operation.
  // ---------------------------------------------------------------------------
  function automatic void sched_reset();
    for (int i = 0; i < NumTasks; i++) begin
      sched.mode[i]      = MODE_READY;
      sched.ticks[i]     = '0;
      sched.flags[i]     = '0;
      sched.wait_mask[i] = '0;
      sched.promise[i]   = '0;
      sched.grp[i]       = '0;
      sched.is_worker[i] = 1'b0;
    end
    sched.top_id       = 0;
    sched.top_worker   = 0;
    sched.cur_id       = '0;
    sched.cur_set      = 1'b0;
    sched.workers_free = 1'b1;
    sched.halted       = 1'b0;
  endfunction

  // Wakes the highest worker that is ready or parked on the event loop.
  function automatic logic wake_worker();
    for (int i = sched.top_worker; i > 0; i--) begin
      if (sched.is_worker[i] && (sched.mode[i] == MODE_WLOOP || sched.mode[i] == MODE_READY)) begin
        sched.mode[i] = MODE_READY;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Scan from the top task down; the current task survives a group tie.
  function automatic logic pick_task();
    int unsigned nxt;
    logic        sw;
    nxt = 0;
    for (int i = sched.top_id; i > 0; i--) begin
      if (sched.mode[i] == MODE_WFLAG && (sched.flags[i] & sched.wait_mask[i]) != '0)
        sched.mode[i] = MODE_READY;
      if (sched.mode[i] == MODE_READY) begin
        nxt = i;
        break;
      end
    end
    if (sched.cur_set && sched.grp[nxt] == sched.grp[sched.cur_id] &&
        sched.mode[sched.cur_id] == MODE_READY)
      nxt = sched.cur_id;
    sw = !sched.cur_set || nxt != sched.cur_id;
    sched.cur_id  = nxt[3:0];
    sched.cur_set = 1'b1;
    return sw;
  endfunction

  function automatic res_t schedule_op(item_t it);
    res_t        r;
    logic        fail;
    logic [3:0]  c;
    int unsigned id;
    r    = '0;
    fail = 1'b0;
    c    = sched.cur_id;
    id   = it.task_id;
    if (!sched.halted) begin
      case (it.op)
        OP_TICK: begin
          for (int i = sched.top_id; i > 0; i--) begin
            if (sched.ticks[i] == 32'd1) begin
              sched.ticks[i] = '0;
              sched.mode[i]  = MODE_READY;
            end else if (sched.ticks[i] != '0) begin
              sched.ticks[i] = sched.ticks[i] - 32'd1;
            end
          end
        end
        OP_ADD: begin
          if (id >= NumTasks) begin
            r.status = ST_BAD_ID;
            fail     = 1'b1;
          end else begin
            if (id > sched.top_id) sched.top_id = id;
            if (it.event_worker && id > sched.top_worker) sched.top_worker = id;
            sched.ticks[id]     = '0;
            sched.flags[id]     = '0;
            sched.wait_mask[id] = '0;
            sched.promise[id]   = '0;
            sched.grp[id]       = it.task_group;
            sched.mode[id]      = it.event_worker ? MODE_WLOOP : MODE_READY;
            sched.is_worker[id] = it.event_worker;
          end
        end
        OP_SLEEP: begin
          if (sched.cur_set) begin
            sched.ticks[c] = it.amount;
            sched.mode[c]  = MODE_WTIME;
          end
        end
        OP_WFLAGS: begin
          if (sched.cur_set) begin
            sched.wait_mask[c] = it.flag_mask;
            sched.ticks[c]     = it.amount;
            sched.mode[c]      = MODE_WFLAG;
          end
        end
        OP_TAKE: begin
          if (sched.cur_set) begin
            r.flags_read   = sched.flags[c];
            sched.flags[c] = sched.flags[c] & ~it.flag_mask;
          end
        end
        OP_SET: begin
          if (id >= NumTasks) r.status = ST_BAD_ID;
          else sched.flags[id] = sched.flags[id] | it.flag_mask;
        end
        OP_AWAIT: begin
          if (sched.cur_set) begin
            sched.promise[c] = it.promise_tag;
            sched.mode[c]    = MODE_WPROM;
            if (!wake_worker()) begin
              r.status = ST_NO_WORKER;
              fail     = 1'b1;
            end else begin
              sched.workers_free = 1'b1;
            end
          end
        end
        OP_RESOLVE: begin
          for (int i = sched.top_worker; i > 0; i--) begin
            if (sched.mode[i] == MODE_WPROM && sched.promise[i] == it.promise_tag) begin
              sched.promise[i] = '0;
              sched.mode[i]    = MODE_READY;
              break;
            end
          end
        end
        OP_IDLE: begin
          if (sched.cur_set) begin
            sched.mode[c]      = MODE_WLOOP;
            sched.workers_free = 1'b0;
          end
        end
        OP_PUSHED: begin
          if (!sched.workers_free) begin
            if (!wake_worker()) begin
              r.status = ST_NO_WORKER;
              fail     = 1'b1;
            end else begin
              sched.workers_free = 1'b1;
            end
          end
        end
        OP_JOIN: begin
          if (!wake_worker()) begin
            r.status = ST_NO_WORKER;
            fail     = 1'b1;
          end else begin
            sched.workers_free = 1'b1;
          end
        end
        default: ;
      endcase
      if (fail) sched.halted = 1'b1;
      else r.switch_request = pick_task();
    end else begin
      r.status = ST_OK;
    end
    r.running_task  = sched.cur_id;
    r.running_valid = sched.cur_set;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender. Items that would halt the block are swapped for a tick unless the
  // caller asks for the halt, so that the random part keeps the table alive.
  // ---------------------------------------------------------------------------
  task automatic send_op(item_t it, logic allow_halt = 1'b0);
    sched_t      saved;
    res_t        r;
    int unsigned gap;
    saved = sched;
    r     = schedule_op(it);
    if (!allow_halt && sched.halted && !saved.halted) begin
      sched = saved;
      it    = '0;
      it.op = OP_TICK;
      r     = schedule_op(it);
    end
    expected_q.push_back(r);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_if.valid        <= 1'b1;
    in_if.op           <= it.op;
    in_if.task_id      <= it.task_id;
    in_if.task_group   <= it.task_group;
    in_if.event_worker <= it.event_worker;
    in_if.amount       <= it.amount;
    in_if.flag_mask    <= it.flag_mask;
    in_if.promise_tag  <= it.promise_tag;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  function automatic item_t make_op(op_e op, int unsigned id = 0, int unsigned grp = 0,
                                    logic worker = 1'b0, logic [31:0] amount = '0,
                                    logic [31:0] mask = '0, logic [31:0] prom = '0);
    item_t it;
    it              = '0;
    it.op           = op;
    it.task_id      = id[4:0];
    it.task_group   = grp[7:0];
    it.event_worker = worker;
    it.amount       = amount;
    it.flag_mask    = mask;
    it.promise_tag  = prom;
    return it;
  endfunction

  // Pauses the sender until every expected result has been drained.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: stalls on its own pattern, honours a long hold-off on request,
  // and checks every result transaction against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    res_t exp_r;
    cycles <= cycles + 1;
    if (out_if.valid && out_if.ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: result transaction with nothing expected", $time);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (out_if.running_task !== exp_r.running_task) begin
          $display("%0t: running_task expected %0d got %0d", $time, exp_r.running_task,
                   out_if.running_task);
          errors++;
        end
        if (out_if.running_valid !== exp_r.running_valid) begin
          $display("%0t: running_valid expected %0b got %0b", $time, exp_r.running_valid,
                   out_if.running_valid);
          errors++;
        end
        if (out_if.switch_request !== exp_r.switch_request) begin
          $display("%0t: switch_request expected %0b got %0b", $time, exp_r.switch_request,
                   out_if.switch_request);
          errors++;
        end
        if (out_if.flags_read !== exp_r.flags_read) begin
          $display("%0t: flags_read expected %h got %h", $time, exp_r.flags_read,
                   out_if.flags_read);
          errors++;
        end
        if (out_if.status !== exp_r.status) begin
          $display("%0t: status expected %0d got %0d", $time, exp_r.status, out_if.status);
          errors++;
        end
      end
    end
    if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
      out_if.ready <= 1'b0;
    end else if ((cycles / 500) % 3 == 0) begin
      out_if.ready <= 1'b1;                       // stretch without stalls
    end else begin
      out_if.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk_i) begin
    if (cycles > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    send_op(make_op(OP_SLEEP, 0, 0, 0, 32'd3));          // nothing scheduled yet
    send_op(make_op(OP_TAKE, 0, 0, 0, 0, 32'hFFFF_FFFF));
    send_op(make_op(OP_TICK));
    send_op(make_op(OP_ADD, 3, 5));
    send_op(make_op(OP_ADD, 15, 255, 1));
    send_op(make_op(OP_ADD, 7, 5));
    send_op(make_op(OP_ADD, 0, 0));
    send_op(make_op(OP_SET, 7, 0, 0, 0, 32'hFFFF_FFFF));
    send_op(make_op(OP_TAKE, 0, 0, 0, 0, 32'h0000_FFFF));
    send_op(make_op(OP_TAKE, 0, 0, 0, 0, 32'hFFFF_FFFF));
    send_op(make_op(OP_SET, 31, 0, 0, 0, 32'h8000_0001)); // id out of range
    send_op(make_op(OP_SET, 16, 0, 0, 0, 32'h1));
    send_op(make_op(OP_WFLAGS, 0, 0, 0, 32'd2, 32'h0000_0100));
    send_op(make_op(OP_SET, 7, 0, 0, 0, 32'h0000_0100));
    send_op(make_op(OP_SLEEP, 0, 0, 0, 32'hFFFF_FFFF));
    send_op(make_op(OP_SLEEP, 0, 0, 0, 32'd1));
    send_op(make_op(OP_TICK));
    send_op(make_op(OP_AWAIT, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
    send_op(make_op(OP_RESOLVE, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
    send_op(make_op(OP_IDLE));
    send_op(make_op(OP_PUSHED));
    send_op(make_op(OP_JOIN));
    send_op(make_op(OP_ADD, 9, 255, 1));
    send_op(make_op(op_e'(4'd11)));                       // unused op code
    send_op(make_op(op_e'(4'd15)));
  endtask

  function automatic item_t random_op();
    item_t       it;
    int unsigned w;
    it              = '0;
    it.task_group   = 8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                     : $urandom_range(0, 3));
    it.event_worker = $urandom_range(0, 2) == 0;
    it.amount       = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 6);
    it.flag_mask    = ($urandom_range(0, 1) == 0) ? $urandom() : (32'd1 << $urandom_range(0, 31));
    it.promise_tag  = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 4);
    w = $urandom_range(0, 99);
    if (w < 10) begin
      it.op      = OP_ADD;
      it.task_id = 5'($urandom_range(0, NumTasks - 1));
    end else if (w < 30) begin
      it.op = OP_TICK;
    end else if (w < 44) begin
      it.op      = OP_SET;
      it.task_id = 5'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                                  : $urandom_range(0, NumTasks - 1));
    end else if (w < 52) it.op = OP_TAKE;
    else if (w < 60) it.op = OP_SLEEP;
    else if (w < 68) it.op = OP_WFLAGS;
    else if (w < 75) it.op = OP_AWAIT;
    else if (w < 83) it.op = OP_RESOLVE;
    else if (w < 88) it.op = OP_IDLE;
    else if (w < 94) it.op = OP_PUSHED;
    else if (w < 98) it.op = OP_JOIN;
    else it.op = op_e'($urandom_range(11, 15));
    return it;
  endfunction

  task automatic test_random(int unsigned n);
    for (int k = 0; k < n; k++) send_op(random_op());
  endtask

  // Receiver holds off while the sender keeps offering, so the block backs up.
  task automatic test_backpressure();
    hold_cycles = 400;
    test_random(20);
  endtask

  // Strip every worker mark, then a join finds nobody: the block must halt and
  // from then on only echo the current task.
  task automatic test_halt();
    for (int i = 0; i < NumTasks; i++) send_op(make_op(OP_ADD, i, i));
    send_op(make_op(OP_JOIN), 1'b1);
    test_random(10);
    send_op(make_op(OP_ADD, 20, 1), 1'b1);
  endtask

  initial begin
    in_if.valid        = 1'b0;
    in_if.op           = OP_TICK;
    in_if.task_id      = '0;
    in_if.task_group   = '0;
    in_if.event_worker = 1'b0;
    in_if.amount       = '0;
    in_if.flag_mask    = '0;
    in_if.promise_tag  = '0;
    out_if.ready       = 1'b0;
    sched_reset();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    drain_results();
    test_random(RandItems / 2);
    test_backpressure();
    drain_results();
    test_random(RandItems / 2);
    drain_results();
    test_halt();
    drain_results();

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/pts_pkg.sv
hdl/pts_if.sv
hdl/pts_table.sv
hdl/pts_seq.sv
hdl/priority_task_scheduler.sv
tb/tb_top.sv
